### rtl/core/bbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Backbone region segmenter package
// Shared widths, codes, item types and the run-closing function.
// ----------------------------------------------------------------------------
package bbs_pkg;

  // Atom index capacity and derived counter widths
  localparam int unsigned MaxAtoms = 65536;
  localparam int unsigned IdxW     = 16;
  localparam int unsigned CntW     = 17;

  // Region queue between classifier and output stage
  localparam int unsigned PushN   = 3;
  localparam int unsigned QDepth  = 8;
  localparam int unsigned QAw     = 3;
  localparam int unsigned QCntW   = 4;

  // Character codes meaning "none" for alt location and insertion code
  localparam logic [7:0] ChNone  = 8'd0;
  localparam logic [7:0] ChSpace = 8'd32;

  // All of N, CA and C seen
  localparam logic [2:0] SeenAll = 3'b111;

  // Saturation limit of the residue count of a run
  localparam logic [1:0] RunSat = 2'd2;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_N     = 2'd1,
    KIND_CA    = 2'd2,
    KIND_C     = 2'd3
  } atom_kind_e;

  typedef enum logic [2:0] {
    RUN_NONE = 3'b001,
    RUN_PART = 3'b010,
    RUN_FULL = 3'b100
  } run_kind_e;

  typedef struct packed {
    logic [15:0]        chain_tag;
    logic [15:0]        model_number;
    logic signed [15:0] residue_number;
    logic [7:0]         ins_code;
    logic [23:0]        residue_name_code;
    logic [1:0]         atom_kind;
    logic [7:0]         alt_location;
    logic               last_atom;
  } atom_t;

  typedef struct packed {
    logic [IdxW-1:0] region_start;
    logic [CntW-1:0] region_end;
    logic            backbone_complete;
    logic            last_region;
    logic            index_overflow;
  } region_t;

  typedef struct packed {
    logic [IdxW-1:0] start;
    run_kind_e       kind;
    logic [1:0]      residues;
  } run_t;

  // Up to three regions produced by one atom, in output order
  typedef struct packed {
    logic [PushN-1:0]          valid;
    region_t [PushN-1:0]       region;
  } push_t;

  typedef struct packed {
    run_t    run;
    logic    emit;
    region_t region;
  } close_t;

  // Close a residue into the open run; emit the run if its kind changes
  function automatic close_t close_residue(run_t run, logic complete,
                                           logic [IdxW-1:0] rs, logic ovf);
    close_t    res;
    run_kind_e kind;
    kind = complete ? RUN_FULL : RUN_PART;
    res.run                      = run;
    res.emit                     = 1'b0;
    res.region.region_start      = run.start;
    res.region.region_end        = {1'b0, rs};
    res.region.backbone_complete = (run.kind == RUN_FULL) && (run.residues >= RunSat);
    res.region.last_region       = 1'b0;
    res.region.index_overflow    = ovf;
    if (run.kind == RUN_NONE) begin
      res.run.kind     = kind;
      res.run.start    = rs;
      res.run.residues = 2'd1;
    end else if (run.kind == kind) begin
      if (run.residues < RunSat) begin
        res.run.residues = run.residues + 2'd1;
      end
    end else begin
      res.emit         = 1'b1;
      res.run.kind     = kind;
      res.run.start    = rs;
      res.run.residues = 2'd1;
    end
    return res;
  endfunction

endpackage

### rtl/core/bbs_atom_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Atom channel
// Valid/ready channel carrying one atom record per transfer.
// ----------------------------------------------------------------------------
interface bbs_atom_if import bbs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [15:0]        chain_tag;
  logic [15:0]        model_number;
  logic signed [15:0] residue_number;
  logic [7:0]         ins_code;
  logic [23:0]        residue_name_code;
  logic [1:0]         atom_kind;
  logic [7:0]         alt_location;
  logic               last_atom;

  modport source (
    output valid, chain_tag, model_number, residue_number, ins_code,
           residue_name_code, atom_kind, alt_location, last_atom,
    input  ready
  );

  modport sink (
    input  valid, chain_tag, model_number, residue_number, ins_code,
           residue_name_code, atom_kind, alt_location, last_atom,
    output ready
  );
endinterface

### rtl/core/bbs_region_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region channel
// Valid/ready channel carrying one atom index region per transfer.
// ----------------------------------------------------------------------------
interface bbs_region_if import bbs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] region_start;
  logic [CntW-1:0] region_end;
  logic            backbone_complete;
  logic            last_region;
  logic            index_overflow;

  modport source (
    output valid, region_start, region_end, backbone_complete, last_region,
           index_overflow,
    input  ready
  );

  modport sink (
    input  valid, region_start, region_end, backbone_complete, last_region,
           index_overflow,
    output ready
  );
endinterface

### rtl/core/bbs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmenter front end
// Classifies each atom against the previous one, tracks residue and run
// state, and hands up to three closed regions per atom to the queue.
// ----------------------------------------------------------------------------
module bbs_front import bbs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  atom_t in_item_i,
  output logic  in_ready_o,
  input  logic  space_i,
  output push_t push_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic            prev_n_q, prev_n_d;
  logic [IdxW-1:0] res_start_q, res_start_d;
  logic [2:0]      seen_q, seen_d;
  logic            raw_q, raw_d;
  run_t            run_q, run_d;
  atom_t           prev_q;

  logic            acc;
  logic            cnt_full;
  logic [IdxW-1:0] idx;
  logic            ovf_new;
  logic            first;
  logic            is_n;
  logic            fresh;
  logic            new_res;
  logic            bad_char;
  logic [2:0]      seen_bit;
  logic [IdxW-1:0] rs1;
  logic [2:0]      seen1, seen2;
  logic            raw1, raw2;
  run_t            run1;
  close_t          c1, c2;
  run_t            run_rst;

  assign in_ready_o = space_i;
  assign acc        = in_valid_i & in_ready_o;

  // Index assignment with saturation at capacity
  assign cnt_full = (cnt_q == CntW'(MaxAtoms));
  assign idx      = cnt_full ? IdxW'(MaxAtoms - 1) : cnt_q[IdxW-1:0];
  assign ovf_new  = ovf_q | cnt_full;
  assign first    = (cnt_q == '0);
  assign is_n     = (in_item_i.atom_kind == KIND_N);

  // Residue boundary detection
  assign fresh = !first &&
                 ((in_item_i.chain_tag         != prev_q.chain_tag)         ||
                  (in_item_i.model_number      != prev_q.model_number)      ||
                  (in_item_i.residue_number    != prev_q.residue_number)    ||
                  (in_item_i.ins_code          != prev_q.ins_code)          ||
                  (in_item_i.residue_name_code != prev_q.residue_name_code) ||
                  (is_n && !prev_n_q));
  assign new_res = first | fresh;

  assign bad_char = ((in_item_i.alt_location != ChNone) &&
                     (in_item_i.alt_location != ChSpace)) ||
                    ((in_item_i.ins_code != ChNone) &&
                     (in_item_i.ins_code != ChSpace));

  assign seen_bit = {in_item_i.atom_kind == KIND_C,
                     in_item_i.atom_kind == KIND_CA,
                     in_item_i.atom_kind == KIND_N};

  // Close the previous residue, then fold in this atom
  always_comb begin
    c1    = close_residue(run_q, (seen_q == SeenAll) && !raw_q, res_start_q, ovf_new);
    run1  = fresh ? c1.run : run_q;
    rs1   = new_res ? idx : res_start_q;
    seen1 = new_res ? 3'b000 : seen_q;
    raw1  = new_res ? 1'b0 : raw_q;
    seen2 = seen1 | seen_bit;
    raw2  = raw1 | bad_char;
    c2    = close_residue(run1, (seen2 == SeenAll) && !raw2, rs1, ovf_new);
  end

  // Regions handed to the queue, in stream order
  always_comb begin
    push_o.valid[0]  = acc & fresh & c1.emit;
    push_o.valid[1]  = acc & in_item_i.last_atom & c2.emit;
    push_o.valid[2]  = acc & in_item_i.last_atom;
    push_o.region[0] = c1.region;
    push_o.region[1] = c2.region;
    push_o.region[2].region_start      = c2.run.start;
    push_o.region[2].region_end        = {1'b0, idx} + CntW'(1);
    push_o.region[2].backbone_complete = (c2.run.kind == RUN_FULL) &&
                                         (c2.run.residues >= RunSat);
    push_o.region[2].last_region       = 1'b1;
    push_o.region[2].index_overflow    = ovf_new;
  end

  // Next state; the final atom returns everything to reset
  always_comb begin
    run_rst     = '{start: '0, kind: RUN_NONE, residues: 2'd0};
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    prev_n_d    = prev_n_q;
    res_start_d = res_start_q;
    seen_d      = seen_q;
    raw_d       = raw_q;
    run_d       = run_q;
    if (acc) begin
      if (in_item_i.last_atom) begin
        cnt_d       = '0;
        ovf_d       = 1'b0;
        prev_n_d    = 1'b0;
        res_start_d = '0;
        seen_d      = 3'b000;
        raw_d       = 1'b0;
        run_d       = run_rst;
      end else begin
        cnt_d       = cnt_full ? cnt_q : cnt_q + CntW'(1);
        ovf_d       = ovf_new;
        prev_n_d    = is_n;
        res_start_d = rs1;
        seen_d      = seen2;
        raw_d       = raw2;
        run_d       = run1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      prev_n_q    <= 1'b0;
      res_start_q <= '0;
      seen_q      <= 3'b000;
      raw_q       <= 1'b0;
      run_q       <= '{start: '0, kind: RUN_NONE, residues: 2'd0};
    end else begin
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      prev_n_q    <= prev_n_d;
      res_start_q <= res_start_d;
      seen_q      <= seen_d;
      raw_q       <= raw_d;
      run_q       <= run_d;
    end
  end

  // Previous atom identity; ignored while the count is zero
  always_ff @(posedge clk_i) begin
    if (acc) begin
      prev_q <= in_item_i;
    end
  end

  // Checks
  a_run_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q.residues != 2'd3)
    else $error("run residue count past saturation");

  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_item_i.last_atom |=> (cnt_q == '0) && (run_q.kind == RUN_NONE))
    else $error("state not cleared after final atom");

  a_final_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid[1] |-> push_o.valid[2])
    else $error("run flush without final region");

endmodule

### rtl/core/bbs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region queue
// Eight-entry queue taking up to three regions per cycle and releasing one.
// ----------------------------------------------------------------------------
module bbs_queue import bbs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  logic    pop_i,
  output logic    head_valid_o,
  output region_t head_o,
  output logic    space_o
);

  region_t          mem_q [QDepth];
  logic [QAw-1:0]   wr_q, wr_d;
  logic [QAw-1:0]   rd_q, rd_d;
  logic [QCntW-1:0] count_q, count_d;
  logic [1:0]       nwr;
  logic [1:0]       off [PushN];

  // Compact the valid regions onto consecutive slots
  always_comb begin
    nwr = 2'd0;
    for (int i = 0; i < PushN; i++) begin
      off[i] = nwr;
      nwr    = nwr + 2'(push_i.valid[i]);
    end
  end

  assign wr_d    = wr_q + QAw'(nwr);
  assign rd_d    = rd_q + QAw'(pop_i);
  assign count_d = count_q + QCntW'(nwr) - QCntW'(pop_i);

  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_q];
  assign space_o      = (count_q <= QCntW'(QDepth - PushN));

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PushN; i++) begin
      if (push_i.valid[i]) begin
        mem_q[wr_q + QAw'(off[i])] <= push_i.region[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // Checks
  a_no_overfill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("region queue overfilled");

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.valid != '0) |-> (count_q <= QCntW'(QDepth - PushN)))
    else $error("regions pushed without room");

endmodule

### rtl/core/bbs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region output stage
// Output register fed from the queue head; refills on the cycle it is taken.
// ----------------------------------------------------------------------------
module bbs_back import bbs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    head_valid_i,
  input  region_t head_i,
  output logic    pop_o,
  output logic    out_valid_o,
  output region_t out_o,
  input  logic    out_ready_i
);

  logic    valid_q, valid_d;
  region_t data_q;

  // Load whenever the register is empty or its content leaves this cycle
  assign pop_o   = head_valid_i & (!valid_q | out_ready_i);
  assign valid_d = pop_o | (valid_q & !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= head_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

### rtl/core/backbone_region_segmenter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Backbone region segmenter
// Groups a stream of atom records into residues and emits runs of residues
// as atom index regions flagged complete or incomplete.
//
//   Channel   Dir  Transfer   Payload
//   atom_i    in   1 atom     chain, model, residue number/name, insertion,
//                             atom kind, alt location, last atom
//   region_o  out  1 region   start, end, backbone complete, last region,
//                             index overflow
//
// One atom is taken per cycle while the queue has room; its regions (none to
// three) are classified in that cycle and queued; the output register drains
// the queue one region per cycle while region_o is ready.
// Reset is asynchronous and leaves the block ready at once; no clearing pass.
// atom_i stalls only when the queue has fewer than three free entries.
// ----------------------------------------------------------------------------
module backbone_region_segmenter import bbs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  bbs_atom_if.sink      atom_i,
  bbs_region_if.source  region_o
);

  atom_t   item;
  push_t   push;
  logic    space;
  logic    pop;
  logic    head_valid;
  region_t head;
  logic    out_valid;
  region_t out;

  assign item.chain_tag         = atom_i.chain_tag;
  assign item.model_number      = atom_i.model_number;
  assign item.residue_number    = atom_i.residue_number;
  assign item.ins_code          = atom_i.ins_code;
  assign item.residue_name_code = atom_i.residue_name_code;
  assign item.atom_kind         = atom_i.atom_kind;
  assign item.alt_location      = atom_i.alt_location;
  assign item.last_atom         = atom_i.last_atom;

  bbs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (atom_i.valid),
    .in_item_i  (item),
    .in_ready_o (atom_i.ready),
    .space_i    (space),
    .push_o     (push)
  );

  bbs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head),
    .space_o      (space)
  );

  bbs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid),
    .out_o        (out),
    .out_ready_i  (region_o.ready)
  );

  assign region_o.valid             = out_valid;
  assign region_o.region_start      = out.region_start;
  assign region_o.region_end        = out.region_end;
  assign region_o.backbone_complete = out.backbone_complete;
  assign region_o.last_region       = out.last_region;
  assign region_o.index_overflow    = out.index_overflow;

endmodule

### test/segmenter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Backbone region segmenter checker
// Watches the atom and region channels, works out the regions that each atom
// transfer closes and compares them, field by field and in order, with the
// regions that the block sends.
// ----------------------------------------------------------------------------
module segmenter_checker import bbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bbs_atom_if         atom_i,
  bbs_region_if       region_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // Regions predicted but not yet seen on the output
  region_t     expected_regions[$];
  region_t     want_region;
  int unsigned mismatches = 0;
  int unsigned pending = 0;

  // Predicted block state
  logic [CntW-1:0] cur_atoms;
  logic [15:0]     prv_chain;
  logic [15:0]     prv_model;
  logic [15:0]     prv_resnum;
  logic [7:0]      prv_icode;
  logic [23:0]     prv_rname;
  logic            prv_was_n;
  logic [IdxW-1:0] res_first;
  logic [2:0]      res_bb;
  logic            res_raw;
  logic [IdxW-1:0] run_first;
  run_kind_e       run_state;
  logic [1:0]      run_len;
  logic            ovf_sticky;

  atom_t atom_seen;

  assign atom_seen = {atom_i.chain_tag, atom_i.model_number, atom_i.residue_number,
                      atom_i.ins_code, atom_i.residue_name_code, atom_i.atom_kind,
                      atom_i.alt_location, atom_i.last_atom};

  assign fail_count_o = mismatches;
  assign pending_o    = pending;

  function automatic void clear_prediction();
    cur_atoms  = '0;
    prv_chain  = '0;
    prv_model  = '0;
    prv_resnum = '0;
    prv_icode  = '0;
    prv_rname  = '0;
    prv_was_n  = 1'b0;
    res_first  = '0;
    res_bb     = '0;
    res_raw    = 1'b0;
    run_first  = '0;
    run_state  = RUN_NONE;
    run_len    = '0;
    ovf_sticky = 1'b0;
  endfunction

  // Flag comes from the open run and overflow from the sticky flag when a region is sent
  function automatic region_t make_region(logic [IdxW-1:0] first, logic [CntW-1:0] past,
                                          logic fin);
    region_t r;
    r.region_start      = first;
    r.region_end        = past;
    r.backbone_complete = (run_state == RUN_FULL) && (run_len >= RunSat);
    r.last_region       = fin;
    r.index_overflow    = ovf_sticky;
    return r;
  endfunction

  // Fold the finished residue into the open run; a change of kind sends the run
  function automatic void end_residue();
    run_kind_e kind;
    kind = (res_bb == SeenAll && !res_raw) ? RUN_FULL : RUN_PART;
    if (run_state == RUN_NONE) begin
      run_state = kind;
      run_first = res_first;
      run_len   = 2'd1;
    end else if (run_state == kind) begin
      if (run_len < RunSat) begin
        run_len = run_len + 2'd1;
      end
    end else begin
      expected_regions = {expected_regions,
                          make_region(run_first, {1'b0, res_first}, 1'b0)};
      run_state = kind;
      run_first = res_first;
      run_len   = 2'd1;
    end
  endfunction

  function automatic void predict_atom(atom_t a);
    logic [IdxW-1:0] idx;
    logic            is_n;
    logic            fresh;
    is_n = (a.atom_kind == KIND_N);
    // Index saturates at the last slot once capacity is used up
    if (cur_atoms >= CntW'(MaxAtoms)) begin
      ovf_sticky = 1'b1;
      idx        = IdxW'(MaxAtoms - 1);
    end else begin
      idx = cur_atoms[IdxW-1:0];
    end
    // First atom of a stream opens a residue without any comparison
    if (cur_atoms == '0) begin
      res_first = idx;
      res_bb    = '0;
      res_raw   = 1'b0;
    end else begin
      fresh = (a.chain_tag != prv_chain) || (a.model_number != prv_model) ||
              (a.residue_number != prv_resnum) || (a.ins_code != prv_icode) ||
              (a.residue_name_code != prv_rname) || (is_n && !prv_was_n);
      if (fresh) begin
        end_residue();
        res_first = idx;
        res_bb    = '0;
        res_raw   = 1'b0;
      end
    end
    if (a.atom_kind != KIND_OTHER) begin
      res_bb[a.atom_kind - 2'd1] = 1'b1;
    end
    if ((a.alt_location != ChNone && a.alt_location != ChSpace) ||
        (a.ins_code != ChNone && a.ins_code != ChSpace)) begin
      res_raw = 1'b1;
    end
    prv_chain  = a.chain_tag;
    prv_model  = a.model_number;
    prv_resnum = a.residue_number;
    prv_icode  = a.ins_code;
    prv_rname  = a.residue_name_code;
    prv_was_n  = is_n;
    if (cur_atoms < CntW'(MaxAtoms)) begin
      cur_atoms = cur_atoms + 1'b1;
    end
    // Final atom closes its residue, flushes the run and restarts the stream
    if (a.last_atom) begin
      end_residue();
      expected_regions = {expected_regions,
                          make_region(run_first, CntW'(idx) + 1'b1, 1'b1)};
      clear_prediction();
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Predict on atom transfers, compare on region transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_prediction();
      expected_regions.delete();
    end else begin
      if (atom_i.valid && atom_i.ready) begin
        predict_atom(atom_seen);
      end
      if (region_i.valid && region_i.ready) begin
        if (expected_regions.size() == 0) begin
          $error("region [%0d,%0d) sent with none expected",
                 region_i.region_start, region_i.region_end);
          mismatches++;
        end else begin
          want_region = expected_regions.pop_front();
          check_field("region_start", want_region.region_start, region_i.region_start);
          check_field("region_end", want_region.region_end, region_i.region_end);
          check_field("backbone_complete", want_region.backbone_complete,
                      region_i.backbone_complete);
          check_field("last_region", want_region.last_region, region_i.last_region);
          check_field("index_overflow", want_region.index_overflow,
                      region_i.index_overflow);
        end
      end
    end
    pending = expected_regions.size();
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Backbone region segmenter testbench
// Drives atom streams into the segmenter: a directed set of edge cases, then
// random residue streams mixed with noise atoms. Both sides idle at random
// and the region side holds off once for a long stretch. The checker
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import bbs_pkg::*;

  localparam int unsigned RandomItems = 1100;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 16;

  // Packed residue names and a few characters
  localparam logic [23:0] ResAla = 24'h414C41;
  localparam logic [23:0] ResGly = 24'h474C59;
  localparam logic [7:0]  ChAltB = 8'h42;
  localparam logic [7:0]  ChInsA = 8'h41;
  localparam logic [15:0] ChainA = 16'h0041;
  localparam logic [15:0] ChainB = 16'h0042;

  logic        clk_i;
  logic        rst_ni;
  logic        quiet;
  int unsigned hold_asks;
  int unsigned items_sent = 0;
  int unsigned fail_count;
  int unsigned pending;

  // Identity of the residue being generated
  logic [15:0] id_chain;
  logic [15:0] id_model;
  logic [15:0] id_resnum;
  logic [7:0]  id_icode;
  logic [23:0] id_rname;

  bbs_atom_if   atom_ch ();
  bbs_region_if region_ch ();

  backbone_region_segmenter dut (
    .clk_i,
    .rst_ni,
    .atom_i   (atom_ch),
    .region_o (region_ch)
  );

  segmenter_checker u_checker (
    .clk_i,
    .rst_ni,
    .atom_i       (atom_ch),
    .region_i     (region_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic atom_t mk_atom(logic [15:0] chain, logic [15:0] model,
                                    logic [15:0] resnum, logic [7:0] icode,
                                    logic [23:0] rname, atom_kind_e kind,
                                    logic [7:0] alt, logic fin);
    atom_t a;
    a.chain_tag         = chain;
    a.model_number      = model;
    a.residue_number    = resnum;
    a.ins_code          = icode;
    a.residue_name_code = rname;
    a.atom_kind         = kind;
    a.alt_location      = alt;
    a.last_atom         = fin;
    return a;
  endfunction

  function automatic logic [23:0] pick_rname();
    if ($urandom_range(0, 3) == 0) begin
      return 24'($urandom);
    end
    return ($urandom_range(0, 1) == 0) ? ResAla : ResGly;
  endfunction

  // Move to the next residue: mostly the next number, sometimes another boundary
  function automatic void step_identity();
    case ($urandom_range(0, 19))
      0: id_chain = ($urandom_range(0, 2) == 0) ? 16'($urandom) : id_chain + 16'd1;
      1: id_model = ($urandom_range(0, 2) == 0) ? 16'($urandom) : id_model + 16'd1;
      2: begin
        // insertion residue: same number, other code
        case ($urandom_range(0, 2))
          0:       id_icode = ChInsA;
          1:       id_icode = ChSpace;
          default: id_icode = 8'($urandom);
        endcase
      end
      3: id_rname = pick_rname();
      4: ;  // same identity, only the N rule splits
      default: begin
        id_resnum = id_resnum + 16'd1;
        id_icode  = ($urandom_range(0, 9) == 0) ? ChSpace : ChNone;
      end
    endcase
  endfunction

  // One transfer, after a random idle burst unless the tail is running
  task automatic send_atom(atom_t a);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      atom_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    atom_ch.valid <= 1'b1;
    {atom_ch.chain_tag, atom_ch.model_number, atom_ch.residue_number,
     atom_ch.ins_code, atom_ch.residue_name_code, atom_ch.atom_kind,
     atom_ch.alt_location, atom_ch.last_atom} <= a;
    @(posedge clk_i);
    while (!atom_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Backbone atoms in order, at times one missing, a repeated N or the order reversed
  task automatic send_residue(bit closing);
    atom_kind_e  order[$];
    int unsigned drop;
    int unsigned bad_alt;
    logic [7:0]  alt;
    drop    = $urandom_range(0, 7);
    bad_alt = $urandom_range(0, 11);
    if ($urandom_range(0, 9) == 0) begin
      order = {order, KIND_C};
      order = {order, KIND_CA};
      order = {order, KIND_N};
    end else begin
      if (drop != 0) order = {order, KIND_N};
      if ($urandom_range(0, 9) == 0) order = {order, KIND_N};
      if (drop != 1) order = {order, KIND_CA};
      if (drop != 2) order = {order, KIND_C};
    end
    repeat ($urandom_range(0, 3)) order = {order, KIND_OTHER};
    foreach (order[i]) begin
      if (bad_alt == i) begin
        alt = 8'($urandom_range(1, 255));
      end else begin
        alt = ($urandom_range(0, 3) == 0) ? ChSpace : ChNone;
      end
      send_atom(mk_atom(id_chain, id_model, id_resnum, id_icode, id_rname, order[i], alt,
                        closing && (i == order.size() - 1)));
    end
  endtask

  task automatic send_stream(int unsigned n_res);
    id_chain  = 16'($urandom_range(0, 3));
    id_model  = 16'd1;
    id_resnum = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd1;
    id_icode  = ChNone;
    id_rname  = pick_rname();
    for (int unsigned r = 0; r < n_res; r++) begin
      if (r != 0) step_identity();
      send_residue(r == n_res - 1);
    end
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned first_random;
    rst_ni    <= 1'b0;
    quiet     <= 1'b0;
    hold_asks <= 0;
    atom_ch.valid <= 1'b0;
    {atom_ch.chain_tag, atom_ch.model_number, atom_ch.residue_number,
     atom_ch.ins_code, atom_ch.residue_name_code, atom_ch.atom_kind,
     atom_ch.alt_location, atom_ch.last_atom} <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone last atoms, all ones and all zeros
    send_atom(mk_atom(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 24'hFFFFFF, KIND_C, 8'hFF, 1'b1));
    send_atom(mk_atom('0, '0, '0, ChNone, '0, KIND_OTHER, ChNone, 1'b1));
    // complete residues at both residue number extremes
    send_atom(mk_atom(ChainA, 16'd1, 16'h8000, ChNone, ResAla, KIND_N, ChNone, 1'b0));
    send_atom(mk_atom(ChainA, 16'd1, 16'h8000, ChNone, ResAla, KIND_CA, ChSpace, 1'b0));
    send_atom(mk_atom(ChainA, 16'd1, 16'h8000, ChNone, ResAla, KIND_C, ChNone, 1'b0));
    send_atom(mk_atom(ChainA, 16'd1, 16'h8000, ChNone, ResAla, KIND_OTHER, ChNone, 1'b0));
    send_atom(mk_atom(ChainA, 16'd1, 16'h7FFF, ChNone, ResAla, KIND_N, ChNone, 1'b0));
    send_atom(mk_atom(ChainA, 16'd1, 16'h7FFF, ChNone, ResAla, KIND_N, ChNone, 1'b0));
    send_atom(mk_atom(ChainA, 16'd1, 16'h7FFF, ChNone, ResAla, KIND_CA, ChNone, 1'b0));
    send_atom(mk_atom(ChainA, 16'd1, 16'h7FFF, ChNone, ResAla, KIND_C, ChNone, 1'b0));
    // missing C
    send_atom(mk_atom(ChainA, 16'd1, 16'd1, ChNone, ResAla, KIND_N, ChNone, 1'b0));
    send_atom(mk_atom(ChainA, 16'd1, 16'd1, ChNone, ResAla, KIND_CA, ChNone, 1'b0));
    // alternate location, then an insertion code
    send_atom(mk_atom(ChainA, 16'd1, 16'd2, ChNone, ResAla, KIND_N, ChAltB, 1'b0));
    send_atom(mk_atom(ChainA, 16'd1, 16'd2, ChNone, ResAla, KIND_CA, ChNone, 1'b0));
    send_atom(mk_atom(ChainA, 16'd1, 16'd2, ChNone, ResAla, KIND_C, ChNone, 1'b0));
    send_atom(mk_atom(ChainA, 16'd1, 16'd2, ChInsA, ResAla, KIND_N, ChNone, 1'b0));
    send_atom(mk_atom(ChainA, 16'd1, 16'd2, ChInsA, ResAla, KIND_CA, ChNone, 1'b0));
    send_atom(mk_atom(ChainA, 16'd1, 16'd2, ChInsA, ResAla, KIND_C, ChNone, 1'b0));
    // reversed backbone: the N splits the residue
    send_atom(mk_atom(ChainA, 16'd1, 16'd3, ChNone, ResAla, KIND_C, ChNone, 1'b0));
    send_atom(mk_atom(ChainA, 16'd1, 16'd3, ChNone, ResAla, KIND_CA, ChNone, 1'b0));
    send_atom(mk_atom(ChainA, 16'd1, 16'd3, ChNone, ResAla, KIND_N, ChNone, 1'b0));
    // chain, model, name and insertion code changes on their own
    send_atom(mk_atom(ChainB, 16'd1, 16'd3, ChNone, ResAla, KIND_CA, ChNone, 1'b0));
    send_atom(mk_atom(ChainB, 16'd2, 16'd3, ChNone, ResAla, KIND_CA, ChNone, 1'b0));
    send_atom(mk_atom(ChainB, 16'd2, 16'd3, ChNone, ResGly, KIND_CA, ChNone, 1'b0));
    send_atom(mk_atom(ChainB, 16'd2, 16'd3, ChSpace, ResGly, KIND_C, ChNone, 1'b1));

    // random streams and noise; the region side holds off once early on
    first_random = items_sent;
    hold_asks <= hold_asks + 1;
    while (items_sent - first_random < RandomItems) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          send_atom(mk_atom(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                            24'($urandom), atom_kind_e'($urandom_range(0, 3)),
                            8'($urandom), $urandom_range(0, 15) == 0));
        end
      end else begin
        send_stream($urandom_range(1, 12));
      end
    end

    // tail at full rate on both sides
    quiet <= 1'b1;
    repeat (4) send_stream($urandom_range(3, 8));
    atom_ch.valid <= 1'b0;

    @(posedge clk_i);
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("backbone_region_segmenter regression: pass");
    end else begin
      $display("backbone_region_segmenter regression: fail");
    end
    $finish;
  end

  // Region side: random stalls, one long hold when asked
  initial begin
    int unsigned holds_done;
    holds_done = 0;
    region_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_asks != holds_done) begin
        holds_done++;
        region_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        region_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      region_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Watchdog: ends the run after too long without any transfer
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((atom_ch.valid && atom_ch.ready) || (region_ch.valid && region_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("backbone_region_segmenter regression: fail");
    $finish;
  end

endmodule

### files.f
rtl/core/bbs_pkg.sv
rtl/core/bbs_atom_if.sv
rtl/core/bbs_region_if.sv
rtl/core/bbs_front.sv
rtl/core/bbs_queue.sv
rtl/core/bbs_back.sv
rtl/core/backbone_region_segmenter.sv
test/segmenter_checker.sv
test/tb_top.sv
